FILE: rtl/core/smc_pkg.sv
package smc_pkg;

    localparam int ACT_W   = 2;
    localparam int IDX_W   = 12;
    localparam int SMP_W   = 12;
    localparam int CFG_W   = 13;
    localparam int OFFS_W  = 12;
    localparam int COST_W  = 24;
    localparam int CIDX_W  = 1;

    typedef logic [ACT_W-1:0] action_t;
    typedef logic [CIDX_W-1:0] cfg_idx_t;

    localparam action_t ACT_WR_PREV = 2'd0;
    localparam action_t ACT_WR_NEXT = 2'd1;
    localparam action_t ACT_MATCH   = 2'd2;
    localparam action_t ACT_READ    = 2'd3;

    localparam cfg_idx_t REG_FRAME_LENGTH  = 1'd0;
    localparam cfg_idx_t REG_APPROX_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0]  FRAME_LENGTH_RST  = 13'd4096;
    localparam logic [CFG_W-1:0]  APPROX_HEIGHT_RST = 13'd2048;
    localparam logic [COST_W-1:0] COST_MAX          = 24'hFFFFFF;

endpackage

FILE: rtl/core/smc_ram.sv
module smc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/seam_match_and_crossfade_core.sv
// Channel   Ports                                   Handshake
// --------  --------------------------------------  ---------------------------
// command   action, index, sample                   start && !busy
// result    sample_out, best_offset, best_cost,     done, one cycle, no stall
//           status
// config    cfg_idx, cfg_wdata                      cfg_we
//
// Sample writes: done in the cycle after start, busy never rises.
// Reads pass through S_READ; refused or degenerate matches end in S_SETUP.
// Full match: S_SETUP, then the SAD walk (one sample pair per cycle through the
// frame RAM read ports), S_DRAIN, then the crossfade (S_XRD to S_XWR per sample,
// two bit-serial divisions per sample in the shared divider).
// Asynchronous active-low reset; frame stores are not cleared.
module seam_match_and_crossfade_core
    import smc_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  action,
    input  logic [IDX_W-1:0]  index,
    input  logic [SMP_W-1:0]  sample,
    output logic              done,
    output logic [SMP_W-1:0]  sample_out,
    output logic [OFFS_W-1:0] best_offset,
    output logic [COST_W-1:0] best_cost,
    output logic              status,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SW   = SAMPLE_BITS;
    localparam int NW   = SAMPLE_BITS + CFG_W;
    localparam int SUMW = SAMPLE_BITS + CFG_W;
    localparam int CW   = $clog2(NW);
    localparam int PW   = CFG_W + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_SAD   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_XRD   = 4'd5;
    localparam logic [3:0] S_XMUL  = 4'd6;
    localparam logic [3:0] S_XDIV1 = 4'd7;
    localparam logic [3:0] S_XDIV2 = 4'd8;
    localparam logic [3:0] S_XWR   = 4'd9;

    logic [3:0]        state_reg;
    logic [CFG_W-1:0]  fl_reg;
    logic [CFG_W-1:0]  ah_reg;

    logic              done_reg;
    logic [SMP_W-1:0]  sample_out_reg;
    logic              status_reg;
    logic [OFFS_W-1:0] match_offset_reg;
    logic [COST_W-1:0] match_cost_reg;
    logic              rd_ok_reg;

    logic [CFG_W-1:0]  width_reg;
    logic [PW-1:0]     offsets_reg;
    logic [CFG_W-1:0]  base_reg;
    logic [CFG_W-1:0]  i_reg;
    logic [PW-1:0]     off_reg;
    logic              drain_reg;

    logic              p1_v_reg;
    logic              p1_first_reg;
    logic              p1_last_reg;
    logic [PW-1:0]     p1_off_reg;
    logic              p2_v_reg;
    logic              p2_first_reg;
    logic              p2_last_reg;
    logic [PW-1:0]     p2_off_reg;
    logic [SW-1:0]     diff_reg;

    logic [SUMW-1:0]   sum_reg;
    logic [SUMW-1:0]   best_reg;
    logic [PW-1:0]     best_off_reg;
    logic              found_reg;

    logic [SW-1:0]     a_reg;
    logic [SW-1:0]     q1_reg;
    logic [NW-1:0]     num_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CW-1:0]     cnt_reg;

    logic              accept;
    logic              idx_ok;
    logic              prev_we;
    logic              next_we;
    logic [AW-1:0]     next_waddr;
    logic [SW-1:0]     next_wdata;
    logic [AW-1:0]     prev_raddr;
    logic [AW-1:0]     next_raddr;
    logic [SW-1:0]     prev_rdata;
    logic [SW-1:0]     next_rdata;

    logic              fl_over;
    logic              ah_over;
    logic [CFG_W-1:0]  ovl;
    logic [CFG_W-1:0]  wid;
    logic [PW-1:0]     last_rd;
    logic              span_bad;

    logic [SW-1:0]     absdiff;
    logic [SUMW-1:0]   total;

    logic [SW-1:0]     mul_x;
    logic [CFG_W-1:0]  mul_y;
    logic [NW-1:0]     prod;
    logic [PW-1:0]     rem_sh;
    logic              div_ge;
    logic [CFG_W-1:0]  rem_next;
    logic [NW-1:0]     quo_next;
    logic              div_last;
    logic [SW-1:0]     xf_value;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign idx_ok = (32'(index) < 32'(MAX_SAMPLES));

    assign done        = done_reg;
    assign sample_out  = sample_out_reg;
    assign status      = status_reg;
    assign best_offset = match_offset_reg;
    assign best_cost   = match_cost_reg;

    // match setup checks
    assign fl_over  = (32'(fl_reg) > 32'(MAX_SAMPLES));
    assign ah_over  = (ah_reg > fl_reg);
    assign ovl      = fl_reg - ah_reg;
    assign wid      = ovl >> 1;
    assign last_rd  = {ovl, 1'b0} - PW'(2);
    assign span_bad = (last_rd >= PW'(fl_reg));

    // frame RAM ports
    assign prev_we    = accept && (action == ACT_WR_PREV) && idx_ok;
    assign next_we    = (accept && (action == ACT_WR_NEXT) && idx_ok) || (state_reg == S_XWR);
    assign next_waddr = (state_reg == S_XWR) ? AW'(best_off_reg + PW'(i_reg)) : AW'(index);
    assign next_wdata = (state_reg == S_XWR) ? xf_value : SW'(sample);
    assign prev_raddr = AW'(PW'(base_reg) + PW'(i_reg));
    assign next_raddr = (state_reg == S_IDLE) ? AW'(index) :
                        AW'(((state_reg == S_SAD) ? off_reg : best_off_reg) + PW'(i_reg));

    smc_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SAMPLES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (AW'(index)),
        .wdata (SW'(sample)),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    smc_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SAMPLES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    // SAD datapath
    assign absdiff = (prev_rdata > next_rdata) ? (prev_rdata - next_rdata)
                                               : (next_rdata - prev_rdata);
    assign total   = (p2_first_reg ? '0 : sum_reg) + SUMW'(diff_reg);

    // shared multiplier and restoring divider for the crossfade
    assign mul_x    = (state_reg == S_XMUL) ? next_rdata : a_reg;
    assign mul_y    = (state_reg == S_XMUL) ? i_reg : (width_reg - i_reg - CFG_W'(1));
    assign prod     = NW'(mul_x) * NW'(mul_y);
    assign rem_sh   = {rem_reg, num_reg[NW-1]};
    assign div_ge   = (rem_sh >= PW'(width_reg));
    assign rem_next = div_ge ? CFG_W'(rem_sh - PW'(width_reg)) : CFG_W'(rem_sh);
    assign quo_next = {num_reg[NW-2:0], div_ge};
    assign div_last = (cnt_reg == CW'(NW - 1));
    assign xf_value = q1_reg + SW'(num_reg);

    // SAD pipeline: RAM read, difference, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= (state_reg == S_SAD);
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_first_reg <= (i_reg == '0);
        p1_last_reg  <= (i_reg == width_reg - CFG_W'(1));
        p1_off_reg   <= off_reg;
        p2_first_reg <= p1_first_reg;
        p2_last_reg  <= p1_last_reg;
        p2_off_reg   <= p1_off_reg;
        diff_reg     <= absdiff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fl_reg           <= FRAME_LENGTH_RST;
            ah_reg           <= APPROX_HEIGHT_RST;
            done_reg         <= 1'b0;
            sample_out_reg   <= '0;
            status_reg       <= 1'b0;
            rd_ok_reg        <= 1'b0;
            match_offset_reg <= '0;
            match_cost_reg   <= '0;
            width_reg        <= '0;
            offsets_reg      <= '0;
            base_reg         <= '0;
            i_reg            <= '0;
            off_reg          <= '0;
            sum_reg          <= '0;
            best_reg         <= '0;
            best_off_reg     <= '0;
            found_reg        <= 1'b0;
            drain_reg        <= 1'b0;
            a_reg            <= '0;
            q1_reg           <= '0;
            num_reg          <= '0;
            rem_reg          <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_FRAME_LENGTH:  fl_reg <= cfg_wdata;
                    REG_APPROX_HEIGHT: ah_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (p2_v_reg)
            begin
                sum_reg <= total;
                if (p2_last_reg && (!found_reg || (total < best_reg)))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= total;
                    best_off_reg <= p2_off_reg;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        sample_out_reg <= '0;
                        status_reg     <= 1'b0;
                        rd_ok_reg      <= idx_ok;
                        unique case (action)
                            ACT_WR_PREV, ACT_WR_NEXT: done_reg  <= 1'b1;
                            ACT_MATCH:                state_reg <= S_SETUP;
                            ACT_READ:                 state_reg <= S_READ;
                            default: ;
                        endcase
                    end
                end

                S_READ:
                begin
                    sample_out_reg <= rd_ok_reg ? SMP_W'(next_rdata) : '0;
                    done_reg       <= 1'b1;
                    state_reg      <= S_IDLE;
                end

                S_SETUP:
                begin
                    if (fl_over || ah_over)
                    begin
                        status_reg <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (ovl == '0)
                    begin
                        match_offset_reg <= '0;
                        match_cost_reg   <= COST_MAX;
                        done_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else if (wid == '0)
                    begin
                        match_offset_reg <= '0;
                        match_cost_reg   <= '0;
                        done_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else if (span_bad)
                    begin
                        status_reg <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        width_reg   <= wid;
                        offsets_reg <= {ovl, 1'b0} - PW'(wid);
                        base_reg    <= fl_reg - wid;
                        i_reg       <= '0;
                        off_reg     <= '0;
                        found_reg   <= 1'b0;
                        state_reg   <= S_SAD;
                    end
                end

                // one sample pair issued per cycle, offsets back to back
                S_SAD:
                begin
                    if (i_reg == width_reg - CFG_W'(1))
                    begin
                        i_reg <= '0;
                        if (off_reg == offsets_reg - PW'(1))
                        begin
                            drain_reg <= 1'b0;
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            off_reg <= off_reg + PW'(1);
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + CFG_W'(1);
                    end
                end

                // let the last sums reach the compare
                S_DRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_XRD;
                    end
                end

                S_XRD:
                begin
                    state_reg <= S_XMUL;
                end

                S_XMUL:
                begin
                    a_reg     <= prev_rdata;
                    num_reg   <= prod;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_XDIV1;
                end

                S_XDIV1:
                begin
                    if (div_last)
                    begin
                        q1_reg    <= SW'(quo_next);
                        num_reg   <= prod;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_XDIV2;
                    end
                    else
                    begin
                        num_reg <= quo_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                S_XDIV2:
                begin
                    num_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (div_last)
                    begin
                        state_reg <= S_XWR;
                    end
                end

                S_XWR:
                begin
                    if (i_reg == width_reg - CFG_W'(1))
                    begin
                        match_offset_reg <= OFFS_W'(best_off_reg);
                        match_cost_reg   <= (best_reg > SUMW'(COST_MAX)) ? COST_MAX
                                                                         : COST_W'(best_reg);
                        done_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CFG_W'(1);
                        state_reg <= S_XRD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
